[rtl/piea_pkg.sv]
// Shared types, codes and elaboration-time helpers for the positional insert/erase array.
// Used by every module of the block; depends on nothing.

package piea_pkg;

    localparam int WORD_W     = 64;
    localparam int CMD_W      = 3;
    localparam int POS_W      = 7;
    localparam int FILL_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int OP_W       = 2;

    // Stream payload layout: 74 used bits, padded to 80.
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 80;
    localparam int IN_USED_W   = CMD_W + POS_W + WORD_W;
    localparam int OUT_USED_W  = WORD_W + FILL_W + 1 + STATUS_W;
    localparam int IN_PAD_W    = IN_TDATA_W - IN_USED_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;

    // Fan-in of each node of the registered read-out tree.
    localparam int TREE_FANIN = 8;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] value;
    } t_cell_ctl;

    // Number of nodes at a given level of the read-out tree (level 0 is the cells).
    function automatic int tree_nodes(input int leaves, input int level);
        int n;
        n = leaves;
        for (int l = 0; l < level; l++) begin
            n = (n + TREE_FANIN - 1) / TREE_FANIN;
        end
        return n;
    endfunction

    // Number of registered levels needed to fold all leaves into one node.
    function automatic int tree_levels(input int leaves);
        int n;
        int l;
        n = leaves;
        l = 0;
        while (n > 1) begin
            n = (n + TREE_FANIN - 1) / TREE_FANIN;
            l = l + 1;
        end
        return l;
    endfunction

    // Position of the first node of a level in the flat node array (levels from 1).
    function automatic int tree_offset(input int leaves, input int level);
        int s;
        s = 0;
        for (int l = 1; l < level; l++) begin
            s = s + tree_nodes(leaves, l);
        end
        return s;
    endfunction

endpackage

[rtl/piea_cell.sv]
// One storage cell of the insert/erase chain: a 64-bit word that takes its own value,
// the new word, or a neighbor's word. Depends on piea_pkg.

module piea_cell #(
    parameter int DEPTH = 64,
    parameter int IDX   = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  piea_pkg::t_cell_ctl         i_ctl,
    input  logic [$clog2(DEPTH)-1:0]    i_pos,
    input  logic [$clog2(DEPTH)-1:0]    i_rd_pos,
    input  logic [piea_pkg::WORD_W-1:0] i_left,
    input  logic [piea_pkg::WORD_W-1:0] i_right,
    output logic [piea_pkg::WORD_W-1:0] o_word,
    output logic [piea_pkg::WORD_W-1:0] o_rd_word
);
    import piea_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] IDX_V = IW'(IDX);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            OP_INSERT: begin
                if (IDX_V > i_pos) begin
                    n_word = i_left;
                end else if (IDX_V == i_pos) begin
                    n_word = i_ctl.value;
                end
            end
            OP_ERASE: begin
                if (IDX_V >= i_pos) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word    = r_word;
    assign o_rd_word = (IDX_V == i_rd_pos) ? r_word : '0;

endmodule

[rtl/piea_read_tree.sv]
// Registered OR tree that folds the gated words of all cells into one read word,
// eight inputs per node and one register per level. Depends on piea_pkg.

module piea_read_tree #(
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic [piea_pkg::WORD_W-1:0] i_leaf [DEPTH],
    output logic [piea_pkg::WORD_W-1:0] o_word
);
    import piea_pkg::*;

    localparam int LEVELS = tree_levels(DEPTH);
    localparam int TOTAL  = tree_offset(DEPTH, LEVELS + 1);

    logic [WORD_W-1:0] w_node [TOTAL];

    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        localparam int NP   = tree_nodes(DEPTH, l - 1);
        localparam int NN   = tree_nodes(DEPTH, l);
        localparam int OFF  = tree_offset(DEPTH, l);
        localparam int POFF = tree_offset(DEPTH, l - 1);
        for (genvar j = 0; j < NN; j++) begin : g_node
            localparam int NC = ((NP - j * TREE_FANIN) < TREE_FANIN) ?
                                (NP - j * TREE_FANIN) : TREE_FANIN;
            logic [WORD_W-1:0] n_or;
            logic [WORD_W-1:0] r_or;
            if (l == 1) begin : g_leaf
                always_comb begin
                    n_or = '0;
                    for (int k = 0; k < NC; k++) begin
                        n_or = n_or | i_leaf[j * TREE_FANIN + k];
                    end
                end
            end else begin : g_inner
                always_comb begin
                    n_or = '0;
                    for (int k = 0; k < NC; k++) begin
                        n_or = n_or | w_node[POFF + j * TREE_FANIN + k];
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                r_or <= n_or;
            end
            assign w_node[OFF + j] = r_or;
        end
    end

    assign o_word = w_node[TOTAL - 1];

endmodule

[rtl/positional_insert_erase_array.sv]
// Top level of the positional insert/erase array: command decode, fill count,
// result register and the chain of cells. Depends on piea_pkg, piea_cell, piea_read_tree.

// A bounded ordered list of up to DEPTH 64-bit words kept packed from cell 0 upward,
// with every cell at or above the fill count holding zero. Each input transfer carries
// one command (append, remove last, insert at position, erase at position, read at
// position) and produces exactly one output transfer with the word read, the fill count
// after the command, an empty flag and a status code. Insert and erase move all cells
// from the position upward at once: each loads the new word or its lower or upper
// neighbor in the same clock, so append, remove, insert, erase, refused and unknown
// commands can follow one another on consecutive cycles while the output is not stalled.
// A successful read is folded out of the chain through a registered eight-input OR tree,
// and no new command is taken until the word has passed the read position register and
// every level of the tree. The result sits in an output register, so a new command is
// taken in the same cycle the previous result is transferred. Reset clears the cells and
// the count directly; there is no clearing pass. Positions are seven bits wide, so
// insert, erase and read reach only the first 128 cells when DEPTH is larger; append
// fills every cell, and the fill count reported is the low seven bits of the count.

module positional_insert_erase_array #(
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // s_axis_tdata from bit 0: command[2:0], position[9:3], value[73:10], zero pad
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [piea_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // m_axis_tdata from bit 0: read_word[63:0], fill_count[70:64], is_empty[71],
    // status[73:72], zero pad
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [piea_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import piea_pkg::*;

    localparam int IW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int XW     = (CW > POS_W) ? CW : POS_W;
    localparam int LEVELS = tree_levels(DEPTH);
    localparam int WAIT_W = $clog2(LEVELS + 1);

    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    // Input fields.
    logic [CMD_W-1:0]  w_cmd;
    logic [POS_W-1:0]  w_pos;
    logic [WORD_W-1:0] w_value;
    logic              w_accept;

    assign w_cmd    = s_axis_tdata[CMD_W-1:0];
    assign w_pos    = s_axis_tdata[CMD_W+POS_W-1:CMD_W];
    assign w_value  = s_axis_tdata[IN_USED_W-1:CMD_W+POS_W];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Control state.
    logic              r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [WAIT_W-1:0] r_wait;
    logic [IW-1:0]     r_rd_pos;
    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Decode of the command against the current count.
    logic [XW-1:0]       w_cnt_x;
    logic [XW-1:0]       w_pos_x;
    logic [XW-1:0]       w_cell_pos_x;
    logic [XW-1:0]       w_fill_x;
    logic [STATUS_W-1:0] w_status;
    logic [OP_W-1:0]     w_op;
    logic                w_read;

    assign w_cnt_x = XW'(r_count);
    assign w_pos_x = XW'(w_pos);

    always_comb begin
        w_status     = ST_OK;
        w_op         = OP_HOLD;
        w_cell_pos_x = w_pos_x;
        w_read       = 1'b0;
        case (w_cmd)
            CMD_APPEND: begin
                if (w_cnt_x == DEPTH_X) begin
                    w_status = ST_FULL;
                end else begin
                    w_op         = OP_INSERT;
                    w_cell_pos_x = w_cnt_x;
                end
            end
            CMD_REMOVE: begin
                if (w_cnt_x == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op         = OP_ERASE;
                    w_cell_pos_x = w_cnt_x - XW'(1);
                end
            end
            CMD_INSERT: begin
                // A position past the end is reported before fullness.
                if (w_pos_x > w_cnt_x) begin
                    w_status = ST_BADPOS;
                end else if (w_cnt_x == DEPTH_X) begin
                    w_status = ST_FULL;
                end else begin
                    w_op = OP_INSERT;
                end
            end
            CMD_ERASE: begin
                if (w_cnt_x == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_op = OP_ERASE;
                end
            end
            CMD_READ: begin
                if (w_pos_x < w_cnt_x) begin
                    w_read = 1'b1;
                end else begin
                    w_status = ST_BADPOS;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            case (w_op)
                OP_INSERT: n_count = r_count + CW'(1);
                OP_ERASE:  n_count = r_count - CW'(1);
                default:   n_count = r_count;
            endcase
        end
    end

    assign w_fill_x = XW'(n_count);

    // Chain of cells. Cell 0 never loads from below and the top cell loads zero on erase.
    t_cell_ctl         w_ctl;
    logic [IW-1:0]     w_cell_pos;
    logic [WORD_W-1:0] w_word    [DEPTH];
    logic [WORD_W-1:0] w_rd_word [DEPTH];
    logic [WORD_W-1:0] w_tree_word;

    assign w_ctl.op    = w_accept ? w_op : OP_HOLD;
    assign w_ctl.value = w_value;
    assign w_cell_pos  = IW'(w_cell_pos_x);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] w_left;
        logic [WORD_W-1:0] w_right;
        if (i == 0) begin : g_bottom
            assign w_left = '0;
        end else begin : g_lower
            assign w_left = w_word[i-1];
        end
        if (i == DEPTH - 1) begin : g_top
            assign w_right = '0;
        end else begin : g_upper
            assign w_right = w_word[i+1];
        end
        piea_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_pos     (w_cell_pos),
            .i_rd_pos  (r_rd_pos),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_word    (w_word[i]),
            .o_rd_word (w_rd_word[i])
        );
    end

    // Only the cell at the read position passes its word, so an OR of all cells
    // yields that word after the tree's register levels.
    piea_read_tree #(
        .DEPTH (DEPTH)
    ) u_read_tree (
        .i_clk  (i_clk),
        .i_leaf (w_rd_word),
        .o_word (w_tree_word)
    );

    // Sequencing and the result register.
    logic                   w_out_free;
    logic                   n_out_load;
    logic [OUT_TDATA_W-1:0] n_out_data;
    logic [CW-1:0]          w_rd_cnt;
    logic [XW-1:0]          w_rd_fill_x;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_rd_cnt      = r_count;
    assign w_rd_fill_x   = XW'(w_rd_cnt);

    always_comb begin
        n_out_load = 1'b0;
        n_out_data = {OUT_PAD_W'(0), w_status, (n_count == '0),
                      w_fill_x[FILL_W-1:0], {WORD_W{1'b0}}};
        case (r_state)
            S_IDLE: begin
                n_out_load = w_accept && !w_read;
            end
            S_READ: begin
                n_out_load = (r_wait == '0) && w_out_free;
                n_out_data = {OUT_PAD_W'(0), ST_OK, (r_count == '0),
                              w_rd_fill_x[FILL_W-1:0], w_tree_word};
            end
            default: begin
                n_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_read) begin
                        r_state <= S_READ;
                        r_wait  <= WAIT_W'(LEVELS);
                    end
                end
                S_READ: begin
                    if (r_wait != '0) begin
                        r_wait <= r_wait - WAIT_W'(1);
                    end else if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_read) begin
            r_rd_pos <= IW'(w_pos_x);
        end
        if (n_out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[rtl/piea_checker.sv]
// Port-level checks on the results of the positional insert/erase array, and the bind
// that attaches them to the top level. Depends on piea_pkg.

module piea_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [piea_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import piea_pkg::*;

    logic [WORD_W-1:0]   w_word;
    logic [FILL_W-1:0]   w_fill;
    logic                w_empty;
    logic [STATUS_W-1:0] w_status;

    assign w_word   = m_axis_tdata[WORD_W-1:0];
    assign w_fill   = m_axis_tdata[WORD_W+FILL_W-1:WORD_W];
    assign w_empty  = m_axis_tdata[WORD_W+FILL_W];
    assign w_status = m_axis_tdata[OUT_USED_W-1:WORD_W+FILL_W+1];

    // An empty list always reports a zero count.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_empty |-> w_fill == '0)
        else $error("empty flag set with a nonzero fill count");

    // A refused or failed command never returns a word.
    a_word_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status != ST_OK |-> w_word == '0)
        else $error("nonzero read word with an error status");

    // Removal from an empty list can only be reported when the list is empty.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status == ST_EMPTY |-> w_empty && w_fill == '0)
        else $error("empty status while entries are stored");

    // A result that is not taken stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

endmodule

bind positional_insert_erase_array piea_checker u_piea_checker (.*);
